### design/tbic_pkg.sv
// ----------------------------------------------------------------------------
// tbic_pkg
// Shared types and constants for the four-tier byte integer codec.
// ----------------------------------------------------------------------------
package tbic_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_VALUE_LIMIT_ONE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VALUE_LIMIT_TWO   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_VALUE_LIMIT_THREE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEAD_LIMIT_ONE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEAD_LIMIT_TWO    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEAD_LIMIT_THREE  = 3'd5;

    localparam logic [31:0] RST_VALUE_LIMIT_ONE   = 32'd128;
    localparam logic [31:0] RST_VALUE_LIMIT_TWO   = 32'd16512;
    localparam logic [31:0] RST_VALUE_LIMIT_THREE = 32'd2113664;
    localparam logic [7:0]  RST_LEAD_LIMIT_ONE    = 8'd128;
    localparam logic [7:0]  RST_LEAD_LIMIT_TWO    = 8'd192;
    localparam logic [7:0]  RST_LEAD_LIMIT_THREE  = 8'd224;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [1:0] TIER_ONE   = 2'd0;
    localparam logic [1:0] TIER_TWO   = 2'd1;
    localparam logic [1:0] TIER_THREE = 2'd2;
    localparam logic [1:0] TIER_FOUR  = 2'd3;

    typedef struct packed {
        logic [31:0] value_limit_one;
        logic [31:0] value_limit_two;
        logic [31:0] value_limit_three;
        logic [7:0]  lead_limit_one;
        logic [7:0]  lead_limit_two;
        logic [7:0]  lead_limit_three;
    } t_cfg;

    // One queued job: either a finished decoded value, or an encoded word whose
    // top byte (selected by tier) already carries the lead offset.
    typedef struct packed {
        logic        is_value;
        logic [1:0]  tier;
        logic [31:0] word;
    } t_job;

endpackage

### design/tbic_front.sv
// ----------------------------------------------------------------------------
// tbic_front
// Accepts items, picks the tier, runs the decoder state and queues jobs.
// ----------------------------------------------------------------------------
module tbic_front import tbic_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_accept,
    input  logic        i_operation,
    input  logic [31:0] i_plain_value,
    input  logic [7:0]  i_code_byte,
    output logic        o_job_valid,
    output t_job        o_job
);

    logic [1:0]  r_pending, n_pending;
    logic [31:0] r_acc, n_acc;
    logic [1:0]  r_tier, n_tier;

    logic [1:0]  enc_tier;
    logic [31:0] enc_base;
    logic [7:0]  enc_lead;
    logic [31:0] enc_rem;
    logic [31:0] enc_word;
    logic [1:0]  lead_tier;
    logic [7:0]  dec_lead;
    logic [31:0] acc_shift;
    logic [31:0] dec_base;
    logic [31:0] dec_value;
    logic [1:0]  pending_dec;

    always_comb begin
        if (i_plain_value < i_cfg.value_limit_one) begin
            enc_tier = TIER_ONE;
        end else if (i_plain_value < i_cfg.value_limit_two) begin
            enc_tier = TIER_TWO;
        end else if (i_plain_value < i_cfg.value_limit_three) begin
            enc_tier = TIER_THREE;
        end else begin
            enc_tier = TIER_FOUR;
        end

        unique case (enc_tier)
            TIER_ONE: begin
                enc_base = 32'd0;
                enc_lead = 8'd0;
            end
            TIER_TWO: begin
                enc_base = i_cfg.value_limit_one;
                enc_lead = i_cfg.lead_limit_one;
            end
            TIER_THREE: begin
                enc_base = i_cfg.value_limit_two;
                enc_lead = i_cfg.lead_limit_two;
            end
            default: begin
                enc_base = i_cfg.value_limit_three;
                enc_lead = i_cfg.lead_limit_three;
            end
        endcase

        enc_rem  = i_plain_value - enc_base;
        enc_word = enc_rem;
        unique case (enc_tier)
            TIER_ONE:   enc_word[7:0]   = enc_rem[7:0] + enc_lead;
            TIER_TWO:   enc_word[15:8]  = enc_rem[15:8] + enc_lead;
            TIER_THREE: enc_word[23:16] = enc_rem[23:16] + enc_lead;
            default:    enc_word[31:24] = enc_rem[31:24] + enc_lead;
        endcase
    end

    always_comb begin
        if (i_code_byte < i_cfg.lead_limit_one) begin
            lead_tier = TIER_ONE;
        end else if (i_code_byte < i_cfg.lead_limit_two) begin
            lead_tier = TIER_TWO;
        end else if (i_code_byte < i_cfg.lead_limit_three) begin
            lead_tier = TIER_THREE;
        end else begin
            lead_tier = TIER_FOUR;
        end

        unique case (lead_tier)
            TIER_ONE:   dec_lead = 8'd0;
            TIER_TWO:   dec_lead = i_cfg.lead_limit_one;
            TIER_THREE: dec_lead = i_cfg.lead_limit_two;
            default:    dec_lead = i_cfg.lead_limit_three;
        endcase

        unique case (r_tier)
            TIER_ONE:   dec_base = 32'd0;
            TIER_TWO:   dec_base = i_cfg.value_limit_one;
            TIER_THREE: dec_base = i_cfg.value_limit_two;
            default:    dec_base = i_cfg.value_limit_three;
        endcase

        acc_shift   = {r_acc[23:0], i_code_byte};
        dec_value   = acc_shift + dec_base;
        pending_dec = r_pending - 2'd1;
    end

    always_comb begin
        n_pending   = r_pending;
        n_acc       = r_acc;
        n_tier      = r_tier;
        o_job_valid = 1'b0;
        o_job       = '{is_value: 1'b0, tier: enc_tier, word: enc_word};

        if (i_accept) begin
            if (i_operation == OP_ENCODE) begin
                o_job_valid = 1'b1;
            end else if (r_pending == 2'd0) begin
                if (lead_tier == TIER_ONE) begin
                    o_job_valid = 1'b1;
                    o_job = '{is_value: 1'b1, tier: TIER_ONE, word: {24'd0, i_code_byte}};
                end else begin
                    n_acc     = {24'd0, i_code_byte - dec_lead};
                    n_tier    = lead_tier;
                    n_pending = lead_tier;
                end
            end else begin
                n_pending = pending_dec;
                if (pending_dec == 2'd0) begin
                    o_job_valid = 1'b1;
                    o_job = '{is_value: 1'b1, tier: TIER_ONE, word: dec_value};
                    n_acc  = 32'd0;
                    n_tier = TIER_ONE;
                end else begin
                    n_acc = acc_shift;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_acc     <= 32'd0;
            r_tier    <= TIER_ONE;
        end else begin
            r_pending <= n_pending;
            r_acc     <= n_acc;
            r_tier    <= n_tier;
        end
    end

endmodule

### design/tbic_queue.sv
// ----------------------------------------------------------------------------
// tbic_queue
// Short job queue between the front and the back of the codec.
// ----------------------------------------------------------------------------
module tbic_queue import tbic_pkg::*; #(
    parameter int Depth = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_empty,
    output logic o_full
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    t_job            r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;

    assign o_empty = (r_count == CntW'(0));
    assign o_full  = (r_count == CntW'(Depth));
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + PtrW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CntW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

### design/tbic_back.sv
// ----------------------------------------------------------------------------
// tbic_back
// Walks an encoded head job byte by byte into the result register, and moves a decoded value into it whole.
// ----------------------------------------------------------------------------
module tbic_back import tbic_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_head,
    input  logic        i_q_empty,
    output logic        o_q_pop,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [7:0]  o_out_byte,
    output logic [31:0] o_out_value,
    output logic        o_is_value,
    output logic        o_last
);

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic [31:0] r_out_value;
    logic        r_is_value;
    logic        r_last;
    logic [1:0]  r_idx, n_idx;

    logic        advance;
    logic        take;
    logic        job_done;
    logic [1:0]  position;
    logic [7:0]  sel_byte;

    assign advance  = !r_out_valid || i_pop;
    assign take     = advance && !i_q_empty;
    assign job_done = i_head.is_value || (r_idx == i_head.tier);
    assign o_q_pop  = take && job_done;
    assign position = i_head.tier - r_idx;

    always_comb begin
        case (position)
            2'd0:    sel_byte = i_head.word[7:0];
            2'd1:    sel_byte = i_head.word[15:8];
            2'd2:    sel_byte = i_head.word[23:16];
            default: sel_byte = i_head.word[31:24];
        endcase

        n_idx = r_idx;
        if (take) begin
            n_idx = job_done ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else begin
            r_idx <= n_idx;
            if (advance) begin
                r_out_valid <= !i_q_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_is_value  <= i_head.is_value;
            r_last      <= job_done;
            r_out_value <= i_head.is_value ? i_head.word : 32'd0;
            r_out_byte  <= i_head.is_value ? 8'd0 : sel_byte;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_value = r_out_value;
    assign o_is_value  = r_is_value;
    assign o_last      = r_last;

endmodule

### design/tiered_byte_integer_codec_core.sv
// ----------------------------------------------------------------------------
// tiered_byte_integer_codec_core
// Four-tier variable-length byte integer encoder and decoder.
// ----------------------------------------------------------------------------
// An item's first result passes the job queue, then the result register. The
// input takes one item per cycle while the queue is not full; the result
// port moves one result per cycle while popped, so a multi-byte encode holds
// it while the job queue absorbs later items. Synchronous reset empties the
// queue and result register, clears the decoder and restores the limits.
module tiered_byte_integer_codec_core import tbic_pkg::*; #(
    parameter int QueueDepth = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    output logic                   o_full,
    input  logic                   i_operation,
    input  logic [31:0]            i_plain_value,
    input  logic [7:0]             i_code_byte,
    output logic                   o_empty,
    input  logic                   i_pop,
    output logic [7:0]             o_out_byte,
    output logic [31:0]            o_out_value,
    output logic                   o_is_value,
    output logic                   o_last,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg r_cfg;
    logic accept;
    logic job_valid;
    t_job job;
    t_job head;
    logic q_empty;
    logic q_full;
    logic q_pop;

    assign o_cfg_ready = 1'b1;
    assign o_full      = q_full;
    assign accept      = i_push && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.value_limit_one   <= RST_VALUE_LIMIT_ONE;
            r_cfg.value_limit_two   <= RST_VALUE_LIMIT_TWO;
            r_cfg.value_limit_three <= RST_VALUE_LIMIT_THREE;
            r_cfg.lead_limit_one    <= RST_LEAD_LIMIT_ONE;
            r_cfg.lead_limit_two    <= RST_LEAD_LIMIT_TWO;
            r_cfg.lead_limit_three  <= RST_LEAD_LIMIT_THREE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VALUE_LIMIT_ONE:   r_cfg.value_limit_one   <= i_cfg_data;
                CFG_VALUE_LIMIT_TWO:   r_cfg.value_limit_two   <= i_cfg_data;
                CFG_VALUE_LIMIT_THREE: r_cfg.value_limit_three <= i_cfg_data;
                CFG_LEAD_LIMIT_ONE:    r_cfg.lead_limit_one    <= i_cfg_data[7:0];
                CFG_LEAD_LIMIT_TWO:    r_cfg.lead_limit_two    <= i_cfg_data[7:0];
                CFG_LEAD_LIMIT_THREE:  r_cfg.lead_limit_three  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    tbic_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_accept      (accept),
        .i_operation   (i_operation),
        .i_plain_value (i_plain_value),
        .i_code_byte   (i_code_byte),
        .o_job_valid   (job_valid),
        .o_job         (job)
    );

    tbic_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_job   (job),
        .i_pop   (q_pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    tbic_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_out_byte  (o_out_byte),
        .o_out_value (o_out_value),
        .o_is_value  (o_is_value),
        .o_last      (o_last)
    );

endmodule

### design/tbic_checker.sv
// ----------------------------------------------------------------------------
// tbic_checker
// Port-level checks for the codec, bound to the top level.
// ----------------------------------------------------------------------------
module tbic_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_full,
    input logic        o_empty,
    input logic        i_pop,
    input logic [7:0]  o_out_byte,
    input logic [31:0] o_out_value,
    input logic        o_is_value,
    input logic        o_last
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty && !o_full)
        else $error("Queues not empty after reset.");

    a_value_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_is_value |-> o_last)
        else $error("Decoded value without last.");

    a_unused_field_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_is_value ? (o_out_byte == 8'd0) : (o_out_value == 32'd0)))
        else $error("Unused result field is not zero.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_out_byte)
            && $stable(o_out_value) && $stable(o_is_value) && $stable(o_last))
        else $error("Waiting result changed before its transfer.");

endmodule

bind tiered_byte_integer_codec_core tbic_checker u_tbic_checker (.*);

### bench/tiered_byte_integer_codec_core_tb.sv
// ----------------------------------------------------------------------------
// tiered_byte_integer_codec_core_tb
// Self-checking bench for the four-tier byte integer codec. A local model of
// the encoder, the decoder state and the six limit registers predicts every
// result, and each popped result is checked field by field against the
// oldest prediction. Directed items cover the tier boundaries, wrapping lead
// bytes, misordered limits and encodes that interrupt a codeword. Random
// phases run under several limit settings, with random gaps on both sides,
// a gap-free stream and one long receiver stall that fills the block.
// ----------------------------------------------------------------------------
module tiered_byte_integer_codec_core_tb;
    import tbic_pkg::*;

    localparam int ClkPeriod   = 12;
    localparam int ResetCycles = 7;
    localparam int SettleCycles = 8;
    localparam int HoldCycles  = 60;
    localparam int StallLimit  = 1000;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [31:0] out_value;
        logic        is_value;
        logic        last;
    } codec_result_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_push;
    logic                   o_full;
    logic                   i_operation;
    logic [31:0]            i_plain_value;
    logic [7:0]             i_code_byte;
    logic                   o_empty;
    logic                   i_pop;
    logic [7:0]             o_out_byte;
    logic [31:0]            o_out_value;
    logic                   o_is_value;
    logic                   o_last;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    t_cfg          limits;
    logic [1:0]    dec_pending;
    logic [31:0]   dec_accum;
    logic [1:0]    dec_tier;
    codec_result_t expected_results[$];
    int            error_count;
    int            stall_count;
    bit            hold_req;
    bit            no_idle;

    tiered_byte_integer_codec_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_operation   (i_operation),
        .i_plain_value (i_plain_value),
        .i_code_byte   (i_code_byte),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_out_byte    (o_out_byte),
        .o_out_value   (o_out_value),
        .o_is_value    (o_is_value),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(ClkPeriod / 2) i_clk = ~i_clk;
    end

    function automatic logic [31:0] tier_base(logic [1:0] tier);
        case (tier)
            TIER_TWO:   return limits.value_limit_one;
            TIER_THREE: return limits.value_limit_two;
            TIER_FOUR:  return limits.value_limit_three;
            default:    return 32'd0;
        endcase
    endfunction

    function automatic logic [7:0] tier_lead(logic [1:0] tier);
        case (tier)
            TIER_TWO:   return limits.lead_limit_one;
            TIER_THREE: return limits.lead_limit_two;
            TIER_FOUR:  return limits.lead_limit_three;
            default:    return 8'd0;
        endcase
    endfunction

    function automatic void add_expected(logic [7:0] b, logic [31:0] v, logic isv, logic lst);
        codec_result_t r;
        r.out_byte  = b;
        r.out_value = v;
        r.is_value  = isv;
        r.last      = lst;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_codec(logic op, logic [31:0] x, logic [7:0] c);
        logic [1:0]  tier;
        logic [31:0] rem;
        logic [31:0] shifted;
        logic [7:0]  b;
        int          nbytes;
        if (op == OP_ENCODE) begin
            if (x < limits.value_limit_one) begin
                add_expected(x[7:0], 32'd0, 1'b0, 1'b1);
            end else begin
                if (x < limits.value_limit_two) tier = TIER_TWO;
                else if (x < limits.value_limit_three) tier = TIER_THREE;
                else tier = TIER_FOUR;
                rem = x - tier_base(tier);
                nbytes = tier + 1;
                for (int i = 0; i < nbytes; i++) begin
                    shifted = rem >> (8 * (nbytes - 1 - i));
                    b = shifted[7:0];
                    if (i == 0) b = shifted[7:0] + tier_lead(tier);
                    add_expected(b, 32'd0, 1'b0, i == nbytes - 1);
                end
            end
        end else if (dec_pending == 2'd0) begin
            if (c < limits.lead_limit_one) begin
                add_expected(8'd0, {24'd0, c}, 1'b1, 1'b1);
            end else begin
                if (c < limits.lead_limit_two) tier = TIER_TWO;
                else if (c < limits.lead_limit_three) tier = TIER_THREE;
                else tier = TIER_FOUR;
                dec_accum   = {24'd0, c} - {24'd0, tier_lead(tier)};
                dec_tier    = tier;
                dec_pending = tier;
            end
        end else begin
            dec_accum   = {dec_accum[23:0], c};
            dec_pending = dec_pending - 2'd1;
            if (dec_pending == 2'd0) begin
                add_expected(8'd0, dec_accum + tier_base(dec_tier), 1'b1, 1'b1);
                dec_accum = 32'd0;
                dec_tier  = TIER_ONE;
            end
        end
    endfunction

    task automatic send_item(logic op, logic [31:0] x, logic [7:0] c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push        <= 1'b1;
        i_operation   <= op;
        i_plain_value <= x;
        i_code_byte   <= c;
        do @(posedge i_clk); while (o_full);
        predict_codec(op, x, c);
    endtask

    task automatic send_encode(logic [31:0] x);
        send_item(OP_ENCODE, x, 8'($urandom));
    endtask

    task automatic send_decode(logic [7:0] c);
        send_item(OP_DECODE, $urandom, c);
    endtask

    task automatic drain();
        i_push <= 1'b0;
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] index, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_VALUE_LIMIT_ONE:   limits.value_limit_one   = data;
            CFG_VALUE_LIMIT_TWO:   limits.value_limit_two   = data;
            CFG_VALUE_LIMIT_THREE: limits.value_limit_three = data;
            CFG_LEAD_LIMIT_ONE:    limits.lead_limit_one    = data[7:0];
            CFG_LEAD_LIMIT_TWO:    limits.lead_limit_two    = data[7:0];
            CFG_LEAD_LIMIT_THREE:  limits.lead_limit_three  = data[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_limits(t_cfg setting);
        logic [23:0] junk;
        drain();
        cfg_write(CFG_VALUE_LIMIT_ONE, setting.value_limit_one);
        cfg_write(CFG_VALUE_LIMIT_TWO, setting.value_limit_two);
        cfg_write(CFG_VALUE_LIMIT_THREE, setting.value_limit_three);
        junk = 24'($urandom);
        cfg_write(CFG_LEAD_LIMIT_ONE, {junk, setting.lead_limit_one});
        junk = 24'($urandom);
        cfg_write(CFG_LEAD_LIMIT_TWO, {junk, setting.lead_limit_two});
        junk = 24'($urandom);
        cfg_write(CFG_LEAD_LIMIT_THREE, {junk, setting.lead_limit_three});
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 255);
            2: return limits.value_limit_one + $urandom_range(0, 4) - 32'd2;
            3: return limits.value_limit_two + $urandom_range(0, 4) - 32'd2;
            4: return limits.value_limit_three + $urandom_range(0, 4) - 32'd2;
            default: return 32'hFFFF_FFFF - $urandom_range(0, 3);
        endcase
    endfunction

    task automatic send_codeword(output int count);
        logic [1:0] tier;
        int         lo;
        int         hi;
        logic [7:0] lead;
        tier = 2'($urandom_range(0, 3));
        case (tier)
            TIER_ONE: begin
                lo = 0;
                hi = int'(limits.lead_limit_one);
            end
            TIER_TWO: begin
                lo = int'(limits.lead_limit_one);
                hi = int'(limits.lead_limit_two);
            end
            TIER_THREE: begin
                lo = int'(limits.lead_limit_two);
                hi = int'(limits.lead_limit_three);
            end
            default: begin
                lo = int'(limits.lead_limit_three);
                hi = 256;
            end
        endcase
        if (lo < hi) lead = 8'($urandom_range(lo, hi - 1));
        else lead = 8'($urandom);
        send_decode(lead);
        for (int i = 0; i < tier; i++) send_decode(8'($urandom));
        count = tier + 1;
    endtask

    task automatic run_random(int n);
        int sent;
        int k;
        int sel;
        sent = 0;
        while (sent < n) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                send_encode(pick_value());
                sent++;
            end else if (sel < 85) begin
                send_codeword(k);
                sent += k;
            end else begin
                send_decode(8'($urandom));
                sent++;
            end
        end
    endtask

    task automatic test_reset_tiers();
        send_encode(32'd0);
        send_encode(32'd127);
        send_encode(32'd128);
        send_encode(32'd16511);
        send_encode(32'd16512);
        send_encode(32'd2113663);
        send_encode(32'd2113664);
        send_encode(32'hFFFF_FFFF);
        send_decode(8'h00);
        send_decode(8'h7F);
        send_decode(8'hBF);
        send_decode(8'hFF);
        send_decode(8'hC0);
        send_decode(8'h00);
        send_decode(8'h00);
        send_decode(8'hFF);
        send_decode(8'hFF);
        send_decode(8'hFF);
        send_decode(8'hFF);
        // An encode in the middle of a codeword leaves the decoder where it was.
        send_decode(8'h80);
        send_encode(32'd5);
        send_decode(8'h12);
    endtask

    task automatic test_wrap_cases();
        t_cfg setting;
        setting.value_limit_one   = 32'h10;
        setting.value_limit_two   = 32'h20;
        setting.value_limit_three = 32'hFFFF_FFF0;
        setting.lead_limit_one    = 8'h10;
        setting.lead_limit_two    = 8'h20;
        setting.lead_limit_three  = 8'h00;
        apply_limits(setting);
        send_decode(8'hFF);
        send_decode(8'hFF);
        send_decode(8'hFF);
        send_decode(8'hFF);
        setting.value_limit_three = 32'h30;
        setting.lead_limit_three  = 8'hF0;
        apply_limits(setting);
        send_encode(32'hFFFF_FFFF);
        send_encode(32'h1F);
        send_encode(32'h2F);
    endtask

    task automatic test_limit_sweep();
        t_cfg setting;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: setting = '0;
                1: setting = '1;
                2: begin
                    setting.value_limit_one   = 32'h0001_0000;
                    setting.value_limit_two   = 32'h0000_0100;
                    setting.value_limit_three = 32'h0100_0000;
                    setting.lead_limit_one    = 8'h40;
                    setting.lead_limit_two    = 8'h20;
                    setting.lead_limit_three  = 8'hE0;
                end
                3: begin
                    setting.value_limit_one   = $urandom;
                    setting.value_limit_two   = $urandom;
                    setting.value_limit_three = $urandom;
                    setting.lead_limit_one    = 8'($urandom);
                    setting.lead_limit_two    = 8'($urandom);
                    setting.lead_limit_three  = 8'($urandom);
                end
                4: begin
                    setting.value_limit_one   = $urandom_range(1, 256);
                    setting.value_limit_two   = setting.value_limit_one
                                                + $urandom_range(0, 65536);
                    setting.value_limit_three = setting.value_limit_two
                                                + $urandom_range(0, 1 << 24);
                    setting.lead_limit_one    = 8'($urandom_range(0, 200));
                    setting.lead_limit_two    =
                        8'($urandom_range(setting.lead_limit_one, 230));
                    setting.lead_limit_three  =
                        8'($urandom_range(setting.lead_limit_two, 255));
                end
                default: begin
                    setting.value_limit_one   = RST_VALUE_LIMIT_ONE;
                    setting.value_limit_two   = RST_VALUE_LIMIT_TWO;
                    setting.value_limit_three = RST_VALUE_LIMIT_THREE;
                    setting.lead_limit_one    = RST_LEAD_LIMIT_ONE;
                    setting.lead_limit_two    = RST_LEAD_LIMIT_TWO;
                    setting.lead_limit_three  = RST_LEAD_LIMIT_THREE;
                end
            endcase
            apply_limits(setting);
            run_random(45);
        end
    endtask

    task automatic test_steady_stream();
        no_idle = 1'b1;
        run_random(60);
        drain();
        no_idle = 1'b0;
    endtask

    task automatic test_receiver_stall();
        hold_req = 1'b1;
        no_idle  = 1'b1;
        for (int i = 0; i < 30; i++) send_encode(32'hF000_0000 | $urandom);
        no_idle = 1'b0;
        drain();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_push        <= 1'b0;
        i_operation   <= OP_ENCODE;
        i_plain_value <= 32'd0;
        i_code_byte   <= 8'd0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_VALUE_LIMIT_ONE;
        i_cfg_data    <= '0;
        error_count = 0;
        hold_req    = 1'b0;
        no_idle     = 1'b0;
        limits.value_limit_one   = RST_VALUE_LIMIT_ONE;
        limits.value_limit_two   = RST_VALUE_LIMIT_TWO;
        limits.value_limit_three = RST_VALUE_LIMIT_THREE;
        limits.lead_limit_one    = RST_LEAD_LIMIT_ONE;
        limits.lead_limit_two    = RST_LEAD_LIMIT_TWO;
        limits.lead_limit_three  = RST_LEAD_LIMIT_THREE;
        dec_pending = 2'd0;
        dec_accum   = 32'd0;
        dec_tier    = TIER_ONE;
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_tiers();
        test_wrap_cases();
        test_limit_sweep();
        test_steady_stream();
        test_receiver_stall();
        drain();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : result_receiver
        int gap;
        i_pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_pop <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                i_pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_pop <= 1'b1;
            do @(posedge i_clk); while (o_empty);
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        codec_result_t want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual byte %h value %h %b %b",
                         $time, o_out_byte, o_out_value, o_is_value, o_last);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("out_byte", {24'd0, want.out_byte}, {24'd0, o_out_byte});
                check_field("out_value", want.out_value, o_out_value);
                check_field("is_value", {31'd0, want.is_value}, {31'd0, o_is_value});
                check_field("last", {31'd0, want.last}, {31'd0, o_last});
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_push && !o_full) || (i_pop && !o_empty)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_count = 0;
        end else begin
            stall_count++;
            if (stall_count >= StallLimit) begin
                $display("%0t: no transfer for %0d cycles", $time, StallLimit);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule
